// ===== hw/rtl/tspr_pkg.sv =====
package tspr_pkg;

  localparam int PID_W      = 13;
  localparam int PID_REG_W  = 14;
  localparam int SLOT_EN_BIT = 13;
  localparam int PCR_W      = 42;
  localparam int BYTES_W    = 64;
  localparam int RATE_W     = 32;
  localparam int OUT_PCR_W  = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAX_SLOTS  = 4;
  localparam int CMD_FIFO_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BITRATE = 3'd0;
  localparam int CFG_PID_BASE = 1;

  localparam int TICKS_PER_SEC = 27000000;
  localparam int BITS_PER_BYTE = 8;
  localparam int SCALE_W = 28;
  localparam logic [SCALE_W-1:0] BIT_TICKS = SCALE_W'(TICKS_PER_SEC * BITS_PER_BYTE);

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_ANCHOR,
    CMD_REWRITE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [PCR_W-1:0]   pcr;
    logic [BYTES_W-1:0] delta;
  } tspr_cmd_t;

endpackage

// ===== hw/rtl/tspr_front.sv =====
module tspr_front #(
  parameter int NUM_PID_SLOTS = 4,
  parameter int PACKET_BYTES  = 188
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tspr_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [tspr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [tspr_pkg::PID_W-1:0]       in_pid,
  input  logic                             in_has_pcr,
  input  logic [tspr_pkg::PCR_W-1:0]       in_pcr,
  input  logic                             in_discontinuity,
  output tspr_pkg::tspr_cmd_t              cmd,
  output logic                             cmd_push,
  input  logic                             cmd_full,
  output logic [tspr_pkg::RATE_W-1:0]      bitrate
);
  import tspr_pkg::*;

  localparam int SLOT_W = (NUM_PID_SLOTS > 1) ? $clog2(NUM_PID_SLOTS) : 1;

  logic [RATE_W-1:0]    bitrate_r;
  logic [PID_REG_W-1:0] watch_r [NUM_PID_SLOTS];
  logic [NUM_PID_SLOTS-1:0] anchor_valid_r;
  logic [PCR_W-1:0]     anchor_pcr_r [NUM_PID_SLOTS];
  logic [BYTES_W-1:0]   anchor_bytes_r [NUM_PID_SLOTS];
  logic [BYTES_W-1:0]   bytes_r;

  logic              cfg_we;
  logic              accept;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  cmd_kind_t         kind;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign full      = cmd_full;
  assign accept    = push & ~cmd_full;
  assign cmd_push  = accept;
  assign bitrate   = bitrate_r;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int k = NUM_PID_SLOTS - 1; k >= 0; k--) begin
      if (watch_r[k][SLOT_EN_BIT] && (watch_r[k][PID_W-1:0] == in_pid)) begin
        hit     = 1'b1;
        hit_idx = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    kind = CMD_PASS;
    if (in_has_pcr && hit) begin
      if (!anchor_valid_r[hit_idx] || in_discontinuity) begin
        kind = CMD_ANCHOR;
      end else if (bitrate_r != '0) begin
        kind = CMD_REWRITE;
      end
    end
  end

  always_comb begin
    cmd.kind  = kind;
    cmd.pcr   = (kind == CMD_REWRITE) ? anchor_pcr_r[hit_idx] : in_pcr;
    cmd.delta = bytes_r - anchor_bytes_r[hit_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bitrate_r      <= '0;
      bytes_r        <= '0;
      anchor_valid_r <= '0;
      for (int k = 0; k < NUM_PID_SLOTS; k++) begin
        watch_r[k] <= '0;
      end
    end else begin
      if (accept) begin
        bytes_r <= bytes_r + BYTES_W'(PACKET_BYTES);
        if (kind == CMD_ANCHOR) begin
          anchor_valid_r[hit_idx] <= 1'b1;
          anchor_pcr_r[hit_idx]   <= in_pcr;
          anchor_bytes_r[hit_idx] <= bytes_r;
        end
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_BITRATE) begin
          bitrate_r <= cfg_data[RATE_W-1:0];
        end
        for (int k = 0; k < NUM_PID_SLOTS; k++) begin
          if (cfg_addr == CFG_IDX_W'(CFG_PID_BASE + k)) begin
            watch_r[k]        <= cfg_data[PID_REG_W-1:0];
            anchor_valid_r[k] <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== hw/rtl/tspr_cmd_fifo.sv =====
module tspr_cmd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  tspr_pkg::tspr_cmd_t wr_data,
  output logic                wr_full,
  input  logic                rd_en,
  output tspr_pkg::tspr_cmd_t rd_data,
  output logic                rd_empty
);
  import tspr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  tspr_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr;
  logic             do_rd;

  assign wr_full  = (count_r == CNT_W'(DEPTH));
  assign rd_empty = (count_r == '0);
  assign do_wr    = wr_en & ~wr_full;
  assign do_rd    = rd_en & ~rd_empty;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/tspr_back.sv =====
module tspr_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tspr_pkg::tspr_cmd_t               cmd,
  input  logic                              cmd_empty,
  output logic                              cmd_pop,
  input  logic [tspr_pkg::RATE_W-1:0]       bitrate,
  output logic                              empty,
  input  logic                              pop,
  output logic [tspr_pkg::OUT_PCR_W-1:0]    out_pcr_out,
  output logic                              out_write_pcr,
  output logic                              out_stamp_event
);
  import tspr_pkg::*;

  localparam int PROD_W = 32 + SCALE_W;
  localparam int CNT_W  = $clog2(BYTES_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV,
    S_EMIT
  } state_t;

  state_t               state_r;
  cmd_kind_t            kind_r;
  logic [PCR_W-1:0]     pcr_r;
  logic [BYTES_W-1:0]   delta_r;
  logic [PROD_W-1:0]    prod_r;
  logic [BYTES_W-1:0]   quo_r;
  logic [RATE_W-1:0]    rem_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 out_valid_r;
  logic [OUT_PCR_W-1:0] out_pcr_r;
  logic                 out_write_r;
  logic                 out_stamp_r;

  logic [PROD_W-1:0]    lo_prod;
  logic [PROD_W-1:0]    hi_prod;
  logic [RATE_W:0]      trial;
  logic [RATE_W:0]      diff;
  logic                 ge;
  logic                 out_free;
  logic [OUT_PCR_W-1:0] emit_pcr;
  logic                 emit_write;
  logic                 emit_stamp;

  assign lo_prod  = delta_r[31:0] * BIT_TICKS;
  assign hi_prod  = delta_r[63:32] * BIT_TICKS;
  assign trial    = {rem_r, quo_r[BYTES_W-1]};
  assign diff     = trial - {1'b0, bitrate};
  assign ge       = (trial >= {1'b0, bitrate});
  assign out_free = ~out_valid_r | pop;
  assign cmd_pop  = (state_r == S_IDLE) & ~cmd_empty;

  assign empty           = ~out_valid_r;
  assign out_pcr_out     = out_pcr_r;
  assign out_write_pcr   = out_write_r;
  assign out_stamp_event = out_stamp_r;

  always_comb begin
    case (kind_r)
      CMD_REWRITE: begin
        emit_pcr   = OUT_PCR_W'(pcr_r) + quo_r;
        emit_write = 1'b1;
        emit_stamp = 1'b1;
      end
      CMD_ANCHOR: begin
        emit_pcr   = OUT_PCR_W'(pcr_r);
        emit_write = 1'b0;
        emit_stamp = 1'b1;
      end
      default: begin
        emit_pcr   = OUT_PCR_W'(pcr_r);
        emit_write = 1'b0;
        emit_stamp = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && pop && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (!cmd_empty) begin
            kind_r  <= cmd.kind;
            pcr_r   <= cmd.pcr;
            delta_r <= cmd.delta;
            state_r <= (cmd.kind == CMD_REWRITE) ? S_MUL_LO : S_EMIT;
          end
        end
        S_MUL_LO: begin
          prod_r  <= lo_prod;
          state_r <= S_MUL_HI;
        end
        S_MUL_HI: begin
          quo_r   <= BYTES_W'(prod_r) + {hi_prod[31:0], 32'b0};
          rem_r   <= '0;
          cnt_r   <= CNT_W'(BYTES_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          rem_r <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
          quo_r <= {quo_r[BYTES_W-2:0], ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pcr_r   <= emit_pcr;
            out_write_r <= emit_write;
            out_stamp_r <= emit_stamp;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/ts_pcr_restamper_core.sv =====
// PCR restamper for an outgoing transport stream.
// Input queue: push one word per outgoing packet (PID, PCR flag, PCR,
// discontinuity) while full is low. Every packet yields exactly one result.
// Result queue: while empty is low the oldest result is on out_*; pop takes it.
// Configuration: cfg_valid/cfg_ready write port, always ready; index 0 is the
// bitrate, indexes 1..4 the watched PID slots. Write only while the block is idle.
// The front classifies each packet in the cycle it is pushed and updates the
// byte count and slot anchors; a two-entry command queue feeds the back end.
// Path: the command queue registers each command; the back end takes it while idle
// and emits it to the result register. A rewritten PCR first passes two 32x28
// partial products and a 64-step restoring divider in the back end; the back end
// takes the next command only after it has emitted the last one.
// If the receiver stalls, the result is held, the back end waits with the next
// result done, the command queue fills and full rises.
// Reset clears the byte count, anchor valid flags, bitrate and slot registers; both queues
// come out empty.
module ts_pcr_restamper_core #(
  parameter int NUM_PID_SLOTS = 4,
  parameter int PACKET_BYTES  = 188
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tspr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [tspr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              push,
  output logic                              full,
  input  logic [tspr_pkg::PID_W-1:0]        in_pid,
  input  logic                              in_has_pcr,
  input  logic [tspr_pkg::PCR_W-1:0]        in_pcr,
  input  logic                              in_discontinuity,
  output logic                              empty,
  input  logic                              pop,
  output logic [tspr_pkg::OUT_PCR_W-1:0]    out_pcr_out,
  output logic                              out_write_pcr,
  output logic                              out_stamp_event
);
  import tspr_pkg::*;

  tspr_cmd_t         fe_cmd;
  tspr_cmd_t         be_cmd;
  logic              fe_push;
  logic              q_full;
  logic              q_empty;
  logic              be_pop;
  logic [RATE_W-1:0] bitrate;

  tspr_front #(
    .NUM_PID_SLOTS (NUM_PID_SLOTS),
    .PACKET_BYTES  (PACKET_BYTES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_addr         (cfg_addr),
    .cfg_data         (cfg_data),
    .push             (push),
    .full             (full),
    .in_pid           (in_pid),
    .in_has_pcr       (in_has_pcr),
    .in_pcr           (in_pcr),
    .in_discontinuity (in_discontinuity),
    .cmd              (fe_cmd),
    .cmd_push         (fe_push),
    .cmd_full         (q_full),
    .bitrate          (bitrate)
  );

  tspr_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fe_push),
    .wr_data  (fe_cmd),
    .wr_full  (q_full),
    .rd_en    (be_pop),
    .rd_data  (be_cmd),
    .rd_empty (q_empty)
  );

  tspr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (be_cmd),
    .cmd_empty       (q_empty),
    .cmd_pop         (be_pop),
    .bitrate         (bitrate),
    .empty           (empty),
    .pop             (pop),
    .out_pcr_out     (out_pcr_out),
    .out_write_pcr   (out_write_pcr),
    .out_stamp_event (out_stamp_event)
  );

endmodule

// ===== hw/rtl/tspr_checker.sv =====
module tspr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [tspr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input logic [tspr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input logic                              push,
  input logic                              full,
  input logic [tspr_pkg::PID_W-1:0]        in_pid,
  input logic                              in_has_pcr,
  input logic [tspr_pkg::PCR_W-1:0]        in_pcr,
  input logic                              in_discontinuity,
  input logic                              empty,
  input logic                              pop,
  input logic [tspr_pkg::OUT_PCR_W-1:0]    out_pcr_out,
  input logic                              out_write_pcr,
  input logic                              out_stamp_event
);
  import tspr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> (empty && !full))
    else $error("queues not empty after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_pcr_out) && $stable(out_write_pcr)
                          && $stable(out_stamp_event)))
    else $error("stalled result word changed");

  a_write_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_write_pcr) |-> out_stamp_event)
    else $error("rewrite without stamp event");

  a_pass_width: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_write_pcr) |-> (out_pcr_out[OUT_PCR_W-1:PCR_W] == '0))
    else $error("passed PCR wider than input");

endmodule

bind ts_pcr_restamper_core tspr_checker u_tspr_checker (.*);
